@@ rtl/rkzf_pkg.sv @@
package rkzf_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int IDX_W            = 11;
    localparam int RES_W            = 12;
    localparam int VAL_W            = 32;
    localparam int RESET_COUNT      = 1024;

    localparam logic [RES_W-1:0] NOT_FOUND = 12'hFFF;
    localparam logic             CMD_WRITE = 1'b0;
    localparam logic             CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] pos;
    } t_result;

endpackage

@@ rtl/range_kth_zero_finder.sv @@
// Channel  | Signals                                       | Direction
// input    | i_in_valid / o_in_ready, command fields       | in
// output   | o_out_valid / i_out_ready, o_found_position   | out
// config   | i_cfg_we, i_cfg_data (element count)          | in
//
// Write: one tree level per cycle through the count memory.
// Query: prefix reads down the tree, then a descent of one memory read then
// one compare per level; bad queries go straight to the result.
// After reset the count memory is swept, one node a cycle, before the first
// beat is taken. Results wait in an output register, so a new beat is taken
// while an earlier result is still unclaimed.
module range_kth_zero_finder import rkzf_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_command,
    input  logic [IDX_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [IDX_W-1:0]        i_range_start,
    input  logic [IDX_W-1:0]        i_range_end,
    input  logic [IDX_W-1:0]        i_rank,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [RES_W-1:0] o_found_position,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_data
);

    localparam logic [IDX_W-1:0] CNT_RST =
        IDX_W'((RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RESET_COUNT);

    logic [IDX_W-1:0] r_elem_count, n_elem_count;
    logic             r_out_valid;
    logic [RES_W-1:0] r_out_pos;
    logic             out_free;
    t_result          res;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_elem_count = r_elem_count;
        if (i_cfg_we) begin
            // clamp into 1 .. MAX_ELEMENTS
            if (i_cfg_data == '0) begin
                n_elem_count = IDX_W'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_ELEMENTS)) begin
                n_elem_count = IDX_W'(MAX_ELEMENTS);
            end else begin
                n_elem_count = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= CNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_elem_count <= n_elem_count;
            if (res.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_pos <= res.pos;
        end
    end

    rkzf_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .i_range_start(i_range_start),
        .i_range_end  (i_range_end),
        .i_rank       (i_rank),
        .i_elem_count (r_elem_count),
        .i_out_free   (out_free),
        .o_res        (res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_found_position = r_out_pos;

endmodule

@@ rtl/rkzf_tree_ram.sv @@
module rkzf_tree_ram import rkzf_pkg::*; #(
    parameter int AW = 11,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rkzf_ctrl.sv @@
module rkzf_ctrl import rkzf_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [IDX_W-1:0]  i_position,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [IDX_W-1:0]  i_range_start,
    input  logic [IDX_W-1:0]  i_range_end,
    input  logic [IDX_W-1:0]  i_rank,
    input  logic [IDX_W-1:0]  i_elem_count,
    input  logic              i_out_free,
    output t_result           o_res
);

    localparam int L  = $clog2(MAX_ELEMENTS);
    localparam int P  = 1 << L;
    localparam int AW = L + 1;
    localparam int CW = L + 1;
    localparam int JW = $clog2(L + 1);
    localparam logic [AW-1:0] ROOT  = AW'(1);
    localparam logic [AW-1:0] P_A   = AW'(P);
    localparam logic [CW-1:0] P_C   = CW'(P);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
    localparam logic [JW-1:0] TOP_J = JW'(L);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_WUPD = 7'b0000100,
        S_PFX  = 7'b0001000,
        S_DRD  = 7'b0010000,
        S_DCHK = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_node, n_node;
    logic [CW-1:0]   r_acc, n_acc;
    logic [CW-1:0]   r_span, n_span;
    logic [CW-1:0]   r_s, n_s;
    logic [AW-1:0]   r_x, n_x;
    logic [AW-1:0]   r_l, n_l;
    logic [IDX_W-1:0] r_rank, n_rank;
    logic [JW-1:0]   r_j, n_j;
    logic            r_issuing, n_issuing;
    logic            r_dv, n_dv;
    logic            r_take, n_take;
    logic            r_dlast, n_dlast;
    logic            r_phase, n_phase;
    logic [CW-1:0]   r_pr, n_pr;
    logic [CW-1:0]   r_k, n_k;
    logic [RES_W-1:0] r_pos, n_pos;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [CW-1:0]   wdata, rdata;

    logic [31:0]     pos32, lm1_32, re32, x32, xs32, sh32, a32, k32, tot32, p32;
    logic [AW-1:0]   leaf, parent, n2, nn;
    logic [CW-1:0]   acc_add, sum, rem, clr_val;
    logic            w_ok, q_bad;

    rkzf_tree_ram #(.AW(AW), .DW(CW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        pos32   = 32'(i_position) - 32'd1;
        lm1_32  = 32'(i_range_start) - 32'd1;
        re32    = 32'(i_range_end);
        leaf    = P_A + {1'b0, pos32[L-1:0]};
        w_ok    = (i_position != '0) && (i_position <= i_elem_count);
        q_bad   = (i_range_start == '0) || (i_range_end > i_elem_count)
                  || (i_range_start > i_range_end) || (i_rank == '0);
        x32     = 32'(r_x);
        xs32    = x32 >> r_j;
        sh32    = 32'(r_j) + 32'd1;
        a32     = (32'(P) + ((x32 >> sh32) << sh32)) >> r_j;
        acc_add = r_acc + (r_take ? rdata : '0);
        tot32   = 32'(r_pr) - 32'(acc_add);
        k32     = 32'(acc_add) + 32'(r_rank);
        parent  = r_node >> 1;
        sum     = r_acc + rdata;
        n2      = {r_node[AW-2:0], 1'b0};
        nn      = (r_k <= rdata) ? n2 : (n2 | AW'(1));
        p32     = 32'(nn[L-1:0]) + 32'd1;
        rem     = MAX_C - r_s;
        clr_val = (r_s >= MAX_C) ? '0 : ((rem >= r_span) ? r_span : rem);
    end

    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_acc     = r_acc;
        n_span    = r_span;
        n_s       = r_s;
        n_x       = r_x;
        n_l       = r_l;
        n_rank    = r_rank;
        n_j       = r_j;
        n_issuing = r_issuing;
        n_dv      = 1'b0;
        n_take    = r_take;
        n_dlast   = r_dlast;
        n_phase   = r_phase;
        n_pr      = r_pr;
        n_k       = r_k;
        n_pos     = r_pos;
        we        = 1'b0;
        waddr     = r_node;
        wdata     = clr_val;
        raddr     = r_node;
        o_in_ready = (r_state == S_IDLE);
        o_res.valid = (r_state == S_DONE) && i_out_free;
        o_res.pos   = r_pos;

        unique case (r_state)
            S_CLR: begin
                // sweep level by level, root first
                we = 1'b1;
                n_node = r_node + AW'(1);
                if (32'(r_s) + 32'(r_span) == 32'(P_C)) begin
                    n_s    = '0;
                    n_span = r_span >> 1;
                    if (r_span == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_s = r_s + r_span;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_WRITE) begin
                        if (w_ok) begin
                            we      = 1'b1;
                            waddr   = leaf;
                            wdata   = (i_new_value == '0) ? CW'(1) : '0;
                            raddr   = leaf ^ AW'(1);
                            n_node  = leaf;
                            n_acc   = wdata;
                            n_state = S_WUPD;
                        end
                    end else if (q_bad) begin
                        n_pos   = NOT_FOUND;
                        n_state = S_DONE;
                    end else begin
                        n_x       = re32[AW-1:0];
                        n_l       = lm1_32[AW-1:0];
                        n_rank    = i_rank;
                        n_j       = TOP_J;
                        n_issuing = 1'b1;
                        n_phase   = 1'b0;
                        n_acc     = '0;
                        n_state   = S_PFX;
                    end
                end
            end
            S_WUPD: begin
                // fold sibling into parent, fetch the next sibling up
                we     = 1'b1;
                waddr  = parent;
                wdata  = sum;
                raddr  = parent ^ AW'(1);
                n_node = parent;
                n_acc  = sum;
                if (parent == ROOT) begin
                    n_state = S_IDLE;
                end
            end
            S_PFX: begin
                if (r_issuing) begin
                    raddr   = a32[AW-1:0];
                    n_dv    = 1'b1;
                    n_take  = xs32[0];
                    n_dlast = (r_j == '0);
                    if (r_j == '0) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_j = r_j - JW'(1);
                    end
                end
                if (r_dv) begin
                    n_acc = acc_add;
                    if (r_dlast) begin
                        if (!r_phase) begin
                            n_pr      = acc_add;
                            n_acc     = '0;
                            n_x       = r_l;
                            n_j       = TOP_J;
                            n_issuing = 1'b1;
                            n_phase   = 1'b1;
                        end else if (tot32 < 32'(r_rank)) begin
                            n_pos   = NOT_FOUND;
                            n_state = S_DONE;
                        end else begin
                            n_k     = k32[CW-1:0];
                            n_node  = ROOT;
                            n_state = S_DRD;
                        end
                    end
                end
            end
            S_DRD: begin
                raddr   = n2;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                n_node = nn;
                if (r_k > rdata) begin
                    n_k = r_k - rdata;
                end
                if (nn[L]) begin
                    n_pos   = p32[RES_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_node    <= ROOT;
            r_span    <= P_C;
            r_s       <= '0;
            r_issuing <= 1'b0;
            r_dv      <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_node    <= n_node;
            r_span    <= n_span;
            r_s       <= n_s;
            r_issuing <= n_issuing;
            r_dv      <= n_dv;
            r_phase   <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_x     <= n_x;
        r_l     <= n_l;
        r_rank  <= n_rank;
        r_j     <= n_j;
        r_take  <= n_take;
        r_dlast <= n_dlast;
        r_pr    <= n_pr;
        r_k     <= n_k;
        r_pos   <= n_pos;
    end

endmodule
